// ===== design/kab_pkg.sv =====
// Shared definitions for the angle/bias Kalman filter block.
// Holds data widths, configuration register indexes and the divider status type.
// No dependencies.
package kab_pkg;

  localparam int DATA_W    = 32;
  localparam int REG_W     = 21;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP     = CFG_IDX_W'(0),
    CFG_ANGLE_NOISE   = CFG_IDX_W'(1),
    CFG_BIAS_NOISE    = CFG_IDX_W'(2),
    CFG_MEASURE_NOISE = CFG_IDX_W'(3)
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== design/kab_mul.sv =====
// Shared fixed-point multiplier with round-half-up and a registered result.
// Depends on nothing; widths come from its parameters.
module kab_mul #(
  parameter int A_W       = 37,
  parameter int B_W       = 32,
  parameter int FRAC_BITS = 20
) (
  input  logic                            clk_i,
  input  logic signed [A_W-1:0]           a_i,
  input  logic signed [B_W-1:0]           b_i,
  output logic signed [A_W+B_W-FRAC_BITS:0] res_o
);

  localparam int P_W = A_W + B_W;
  localparam logic signed [P_W:0] HALF =
    {{(P_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [P_W-1:0] prod;
  logic signed [P_W:0]   rsum;

  assign prod = a_i * b_i;
  assign rsum = (P_W+1)'(prod) + HALF;

  always_ff @(posedge clk_i) begin
    res_o <= rsum[P_W:FRAC_BITS];
  end

endmodule

// ===== design/kab_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Kalman gain.
// Computes (num * 2^FRAC_BITS) / den toward zero, saturated to 32 bits.
// Depends on kab_pkg.
module kab_div #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [kab_pkg::DATA_W-1:0]   num_i,
  input  logic signed [kab_pkg::DATA_W-1:0]   den_i,
  output logic signed [kab_pkg::DATA_W-1:0]   quo_o,
  output kab_pkg::div_sts_t                   sts_o
);
  import kab_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'({1'b1, {(DATA_W-1){1'b0}}});
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic              busy_q, fin_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [NUM_W-1:0]  acc_q;
  logic [DATA_W-1:0] dvs_q, rem_q;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic [DATA_W-1:0] num_mag, den_mag;
  logic signed [DATA_W-1:0] quo_q, sat_val;
  logic              den_zero;

  assign num_mag  = num_i[DATA_W-1] ? DATA_W'(-num_i) : num_i;
  assign den_mag  = den_i[DATA_W-1] ? DATA_W'(-den_i) : den_i;
  assign den_zero = (den_i == '0);
  assign rem_sh   = {rem_q, acc_q[NUM_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    if (neg_q) begin
      sat_val = (acc_q > NEG_LIM) ? Q_MIN : DATA_W'(-acc_q[DATA_W-1:0]);
    end else begin
      sat_val = (acc_q > POS_LIM) ? Q_MAX : acc_q[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q || (start_i && den_zero);
      fin_q  <= !start_i && busy_q && (cnt_q == CNT_W'(NUM_W-1));
      if (start_i) begin
        if (!den_zero) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W-1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {num_mag, {FRAC_BITS{1'b0}}};
      dvs_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
      if (den_zero) begin
        quo_q <= '0;
      end
    end else if (busy_q) begin
      rem_q <= diff[DATA_W+1] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
      acc_q <= {acc_q[NUM_W-2:0], ~diff[DATA_W+1]};
    end else if (fin_q) begin
      quo_q <= sat_val;
    end
  end

  assign quo_o      = quo_q;
  assign sts_o.busy = busy_q | fin_q;
  assign sts_o.done = done_q;

endmodule

// ===== design/kalman_angle_bias_filter.sv =====
// Two-state Kalman filter for angle and gyro bias, top level with sequencer.
// Depends on kab_pkg, kab_mul and kab_div.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  measured_angle, turn_rate
// m_axis    out        m_axis_tvalid/m_axis_tready  angle_out, bias_out
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// A request is accepted only in idle, so each runs to its posted result before
// the next is taken; the two gain divisions on the one-bit-per-cycle divider
// account for most of the run, the shared multiplier for the rest.
// A zero innovation variance makes the divider return a zero gain at once and shortens the run.
// Reset restores the register defaults, zero estimates and a unit covariance.
// A held result stalls the sequencer only at its final step.
module kalman_angle_bias_filter #(
  parameter int FRAC_BITS = 20
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // measured_angle [31:0], turn_rate [63:32]
  input  logic [2*kab_pkg::DATA_W-1:0]         s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // angle_out [31:0], bias_out [63:32]
  output logic [2*kab_pkg::DATA_W-1:0]         m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [kab_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [kab_pkg::REG_W-1:0]            cfg_data_i
);
  import kab_pkg::*;

  localparam int U_W   = REG_W + 34 - FRAC_BITS;
  localparam int T_W   = ((U_W > DATA_W) ? U_W : DATA_W) + 2;
  localparam int MA_W  = (T_W > DATA_W + 1) ? T_W : DATA_W + 1;
  localparam int MB_W  = DATA_W;
  localparam int R_W   = MA_W + MB_W + 1 - FRAC_BITS;
  localparam int SUM_W = R_W + 2;

  localparam logic [REG_W-1:0] DT_RST = REG_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic [REG_W-1:0] QA_RST = REG_W'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [REG_W-1:0] QB_RST = REG_W'((3 * (1 << FRAC_BITS) + 500) / 1000);
  localparam logic [REG_W-1:0] RN_RST = REG_W'((3 * (1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'(1) << FRAC_BITS);

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PR0, ST_PR1, ST_PR2, ST_PR3, ST_PR4, ST_PR5,
    ST_K0_GO, ST_K0_WAIT, ST_K1_GO, ST_K1_WAIT,
    ST_UP0, ST_UP1, ST_UP2, ST_UP3, ST_UP4, ST_UP5, ST_UP6,
    ST_OUT
  } state_e;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[DATA_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  state_e state_q;

  logic [REG_W-1:0] dt_q, qa_q, qb_q, rn_q;
  logic signed [REG_W:0] dt_s, qa_s, qb_s, rn_s;

  logic signed [DATA_W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic signed [DATA_W-1:0] meas_q, rate_q, pp00_q, pp01_q, pp10_q, pp11_q;
  logic signed [DATA_W-1:0] y_q, s_q, k0_q, k1_q;
  logic signed [T_W-1:0]    t_q;
  logic signed [DATA_W:0]   rate_diff;

  logic                     m_valid_q;
  logic [2*DATA_W-1:0]      m_data_q;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [R_W-1:0]    mul_r;

  logic                     div_start;
  logic signed [DATA_W-1:0] div_num, div_quo;
  div_sts_t                 div_sts;

  logic                     in_acc;

  assign dt_s = $signed({1'b0, dt_q});
  assign qa_s = $signed({1'b0, qa_q});
  assign qb_s = $signed({1'b0, qb_q});
  assign rn_s = $signed({1'b0, rn_q});

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  assign rate_diff = (DATA_W+1)'(rate_q) - (DATA_W+1)'(bias_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= DT_RST;
      qa_q <= QA_RST;
      qb_q <= QB_RST;
      rn_q <= RN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TIME_STEP:     dt_q <= cfg_data_i;
        CFG_ANGLE_NOISE:   qa_q <= cfg_data_i;
        CFG_BIAS_NOISE:    qb_q <= cfg_data_i;
        CFG_MEASURE_NOISE: rn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PR0: begin
        mul_a = MA_W'(rate_diff);
        mul_b = MB_W'(dt_s);
      end
      ST_PR1: begin
        mul_a = MA_W'(p11_q);
        mul_b = MB_W'(dt_s);
      end
      ST_PR2: begin
        mul_a = MA_W'(qb_s);
        mul_b = MB_W'(dt_s);
      end
      ST_PR3: begin
        mul_a = MA_W'(t_q);
        mul_b = MB_W'(dt_s);
      end
      ST_UP0: begin
        mul_a = MA_W'(y_q);
        mul_b = k0_q;
      end
      ST_UP1: begin
        mul_a = MA_W'(y_q);
        mul_b = k1_q;
      end
      ST_UP2: begin
        mul_a = MA_W'(pp00_q);
        mul_b = k0_q;
      end
      ST_UP3: begin
        mul_a = MA_W'(pp01_q);
        mul_b = k0_q;
      end
      ST_UP4: begin
        mul_a = MA_W'(pp00_q);
        mul_b = k1_q;
      end
      ST_UP5: begin
        mul_a = MA_W'(pp01_q);
        mul_b = k1_q;
      end
      default: ;
    endcase
  end

  kab_mul #(
    .A_W       (MA_W),
    .B_W       (MB_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_r)
  );

  assign div_start = (state_q == ST_K0_GO) || (state_q == ST_K1_GO);
  assign div_num   = (state_q == ST_K1_GO) ? pp10_q : pp00_q;

  kab_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (s_q),
    .quo_o   (div_quo),
    .sts_o   (div_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      ang_q     <= '0;
      bias_q    <= '0;
      p00_q     <= ONE_Q;
      p01_q     <= '0;
      p10_q     <= '0;
      p11_q     <= ONE_Q;
    end else begin
      if (m_axis_tready && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= ST_PR0;
          end
        end
        ST_PR0: state_q <= ST_PR1;
        ST_PR1: begin
          ang_q   <= sat(SUM_W'(ang_q) + SUM_W'(mul_r));
          state_q <= ST_PR2;
        end
        ST_PR2: state_q <= ST_PR3;
        ST_PR3: state_q <= ST_PR4;
        ST_PR4: state_q <= ST_PR5;
        ST_PR5: state_q <= ST_K0_GO;
        ST_K0_GO: state_q <= ST_K0_WAIT;
        ST_K0_WAIT: begin
          if (div_sts.done) begin
            state_q <= ST_K1_GO;
          end
        end
        ST_K1_GO: state_q <= ST_K1_WAIT;
        ST_K1_WAIT: begin
          if (div_sts.done) begin
            state_q <= ST_UP0;
          end
        end
        ST_UP0: state_q <= ST_UP1;
        ST_UP1: begin
          ang_q   <= sat(SUM_W'(ang_q) + SUM_W'(mul_r));
          state_q <= ST_UP2;
        end
        ST_UP2: begin
          bias_q  <= sat(SUM_W'(bias_q) + SUM_W'(mul_r));
          state_q <= ST_UP3;
        end
        ST_UP3: begin
          p00_q   <= sat(SUM_W'(pp00_q) - SUM_W'(mul_r));
          state_q <= ST_UP4;
        end
        ST_UP4: begin
          p01_q   <= sat(SUM_W'(pp01_q) - SUM_W'(mul_r));
          state_q <= ST_UP5;
        end
        ST_UP5: begin
          p10_q   <= sat(SUM_W'(pp10_q) - SUM_W'(mul_r));
          state_q <= ST_UP6;
        end
        ST_UP6: begin
          p11_q   <= sat(SUM_W'(pp11_q) - SUM_W'(mul_r));
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {bias_q, ang_q};
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          meas_q <= s_axis_tdata[DATA_W-1:0];
          rate_q <= s_axis_tdata[2*DATA_W-1:DATA_W];
        end
      end
      ST_PR2: begin
        pp01_q <= sat(SUM_W'(p01_q) - SUM_W'(mul_r));
        pp10_q <= sat(SUM_W'(p10_q) - SUM_W'(mul_r));
        t_q    <= T_W'(mul_r) - T_W'(p01_q) - T_W'(p10_q) + T_W'(qa_s);
        y_q    <= sat(SUM_W'(meas_q) - SUM_W'(ang_q));
      end
      ST_PR3: pp11_q <= sat(SUM_W'(p11_q) + SUM_W'(mul_r));
      ST_PR4: pp00_q <= sat(SUM_W'(p00_q) + SUM_W'(mul_r));
      ST_PR5: s_q    <= sat(SUM_W'(pp00_q) + SUM_W'(rn_s));
      ST_K0_WAIT: begin
        if (div_sts.done) begin
          k0_q <= div_quo;
        end
      end
      ST_K1_WAIT: begin
        if (div_sts.done) begin
          k1_q <= div_quo;
        end
      end
      default: ;
    endcase
  end

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_sts.busy)
    else $error("divider busy while input is open");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == ST_K0_WAIT || state_q == ST_K1_WAIT))
    else $error("divider result arrived outside a wait state");

  a_accept_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("input still open after a request was taken");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && m_valid_q && !m_axis_tready) |=> (state_q == ST_OUT))
    else $error("result overwrote an unread output");

endmodule

// ===== tb/kalman_angle_bias_filter_tb.sv =====
// Self-checking testbench for kalman_angle_bias_filter: stream requests in and results out.
// A scoreboard class predicts each angle/bias result, with random idling on every channel.
// Depends on kab_pkg and the kalman_angle_bias_filter design.
`timescale 1ns / 100ps

module kalman_angle_bias_filter_tb;
  import kab_pkg::*;

  localparam int FRAC_BITS = 20;
  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint HALF = longint'(1) << (FRAC_BITS - 1);
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic [REG_W-1:0] REG_MAX = 21'h1F_FFFF;
  localparam int ANGLE_SPAN = 188743680;
  localparam int RATE_SPAN = 262144000;
  localparam int DRAIN_CYCLES = 2 * FRAC_BITS + 125;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 100;

  class filter_checker;
    typedef struct {
      logic signed [DATA_W-1:0] angle;
      logic signed [DATA_W-1:0] bias;
    } estimate_t;

    estimate_t expected_estimates[$];
    int failures;
    logic [REG_W-1:0] step_size;
    logic [REG_W-1:0] angle_noise;
    logic [REG_W-1:0] bias_noise;
    logic [REG_W-1:0] meas_noise;
    logic signed [DATA_W-1:0] est_angle;
    logic signed [DATA_W-1:0] est_bias;
    logic signed [DATA_W-1:0] cov_aa;
    logic signed [DATA_W-1:0] cov_ab;
    logic signed [DATA_W-1:0] cov_ba;
    logic signed [DATA_W-1:0] cov_bb;

    function new();
      failures = 0;
      step_size = REG_W'((ONE + 50) / 100);
      angle_noise = REG_W'((ONE + 500) / 1000);
      bias_noise = REG_W'((3 * ONE + 500) / 1000);
      meas_noise = REG_W'((3 * ONE + 50) / 100);
      est_angle = '0;
      est_bias = '0;
      cov_aa = DATA_W'(ONE);
      cov_ab = '0;
      cov_ba = '0;
      cov_bb = DATA_W'(ONE);
    endfunction

    function longint clamp_word(longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
    endfunction

    function longint fx_mul(longint a, longint b);
      return (a * b + HALF) >>> FRAC_BITS;
    endfunction

    function longint fx_div(longint num, longint den);
      if (den == 0) return 0;
      return clamp_word((num * ONE) / den);
    endfunction

    function int pending();
      return expected_estimates.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
      case (cfg_idx_e'(idx))
        CFG_TIME_STEP:     step_size = value;
        CFG_ANGLE_NOISE:   angle_noise = value;
        CFG_BIAS_NOISE:    bias_noise = value;
        CFG_MEASURE_NOISE: meas_noise = value;
        default: ;
      endcase
    endfunction

    function void accept_sample(logic signed [DATA_W-1:0] meas_w,
                                logic signed [DATA_W-1:0] rate_w);
      longint meas, rate, dt, qa, qb, rn, ang, bia, aa, ab, ba, bb;
      longint p00, p01, p10, p11, innov, var_sum, k0, k1;
      estimate_t want;
      meas = meas_w;
      rate = rate_w;
      dt = step_size;
      qa = angle_noise;
      qb = bias_noise;
      rn = meas_noise;
      ang = est_angle;
      bia = est_bias;
      aa = cov_aa;
      ab = cov_ab;
      ba = cov_ba;
      bb = cov_bb;

      ang = clamp_word(ang + fx_mul(dt, rate - bia));
      p00 = clamp_word(aa + fx_mul(dt, fx_mul(dt, bb) - ab - ba + qa));
      p01 = clamp_word(ab - fx_mul(dt, bb));
      p10 = clamp_word(ba - fx_mul(dt, bb));
      p11 = clamp_word(bb + fx_mul(qb, dt));

      innov = clamp_word(meas - ang);
      var_sum = clamp_word(p00 + rn);
      k0 = fx_div(p00, var_sum);
      k1 = fx_div(p10, var_sum);

      ang = clamp_word(ang + fx_mul(k0, innov));
      bia = clamp_word(bia + fx_mul(k1, innov));

      est_angle = ang[DATA_W-1:0];
      est_bias = bia[DATA_W-1:0];
      cov_aa = DATA_W'(clamp_word(p00 - fx_mul(k0, p00)));
      cov_ab = DATA_W'(clamp_word(p01 - fx_mul(k0, p01)));
      cov_ba = DATA_W'(clamp_word(p10 - fx_mul(k1, p00)));
      cov_bb = DATA_W'(clamp_word(p11 - fx_mul(k1, p01)));

      want.angle = est_angle;
      want.bias = est_bias;
      expected_estimates.push_back(want);
    endfunction

    function void check_estimate(logic signed [DATA_W-1:0] angle,
                                 logic signed [DATA_W-1:0] bias);
      estimate_t want;
      if (expected_estimates.size() == 0) begin
        $error("result with no request pending: angle_out %0d bias_out %0d", angle, bias);
        failures++;
        return;
      end
      want = expected_estimates.pop_front();
      if (angle !== want.angle) begin
        $error("angle_out mismatch: expected %0d, actual %0d", want.angle, angle);
        failures++;
      end
      if (bias !== want.bias) begin
        $error("bias_out mismatch: expected %0d, actual %0d", want.bias, bias);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [2*DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*DATA_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [REG_W-1:0] cfg_data_i = '0;

  filter_checker board;
  bit no_gaps = 1'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  kalman_angle_bias_filter #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 200);
  endfunction

  function automatic logic [REG_W-1:0] pick_register_value();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return '0;
      1: return REG_W'(1);
      2: return REG_W'(ONE);
      3: return REG_MAX;
      4: return REG_W'($urandom);
      default: return REG_W'($urandom_range(1, 65536));
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word(int span);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return int'($urandom_range(0, 2 * span)) - span;
    if (roll < 9) return $urandom;
    case ($urandom_range(0, 3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (no_gaps || $urandom_range(0, 3) != 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_hold <= pick_gap();
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        board.accept_sample(s_axis_tdata[DATA_W-1:0], s_axis_tdata[2*DATA_W-1:DATA_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        board.check_estimate(m_axis_tdata[DATA_W-1:0], m_axis_tdata[2*DATA_W-1:DATA_W]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic signed [DATA_W-1:0] meas,
                             input logic signed [DATA_W-1:0] rate);
    int gap;
    gap = pick_gap();
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rate, meas};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_realistic(input int count);
    for (int n = 0; n < count; n++) begin
      send_sample(int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN,
                  int'($urandom_range(0, 2 * RATE_SPAN)) - RATE_SPAN);
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, then the input extremes that drive the estimates into saturation.
    send_sample('0, '0);
    send_sample(DATA_W'(ONE), '0);
    send_sample(WORD_MAX, WORD_MAX);
    send_sample(WORD_MIN, WORD_MIN);
    send_sample(WORD_MAX, WORD_MIN);
    send_sample(WORD_MIN, WORD_MAX);
    wait_for_results();

    // With no time step, no noise and a zero measurement noise, the first request
    // collapses the angle variance and the following ones see a zero divisor.
    write_register(CFG_TIME_STEP, '0);
    write_register(CFG_ANGLE_NOISE, '0);
    write_register(CFG_BIAS_NOISE, '0);
    write_register(CFG_MEASURE_NOISE, '0);
    send_realistic(3);
    wait_for_results();

    write_register(CFG_TIME_STEP, REG_MAX);
    write_register(CFG_ANGLE_NOISE, REG_MAX);
    write_register(CFG_BIAS_NOISE, REG_MAX);
    write_register(CFG_MEASURE_NOISE, REG_MAX);
    write_register(CFG_IDX_W'($urandom_range(4, 15)), '0);
    send_sample(WORD_MAX, WORD_MIN);
    send_sample(WORD_MIN, WORD_MAX);
    send_sample('0, '1);
    send_sample('1, '0);
    wait_for_results();

    write_register(CFG_TIME_STEP, REG_W'(ONE));
    write_register(CFG_ANGLE_NOISE, REG_W'(1));
    write_register(CFG_BIAS_NOISE, REG_W'(1));
    write_register(CFG_MEASURE_NOISE, REG_W'(1));
    send_realistic(4);
    wait_for_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      no_gaps = (phase % 4 == 1);
      if (phase == 0) begin
        write_register(CFG_TIME_STEP, REG_W'((ONE + 50) / 100));
        write_register(CFG_ANGLE_NOISE, REG_W'((ONE + 500) / 1000));
        write_register(CFG_BIAS_NOISE, REG_W'((3 * ONE + 500) / 1000));
        write_register(CFG_MEASURE_NOISE, REG_W'((3 * ONE + 50) / 100));
      end else begin
        if ($urandom_range(0, 1)) write_register(CFG_TIME_STEP, pick_register_value());
        if ($urandom_range(0, 1)) write_register(CFG_ANGLE_NOISE, pick_register_value());
        if ($urandom_range(0, 1)) write_register(CFG_BIAS_NOISE, pick_register_value());
        if ($urandom_range(0, 1)) write_register(CFG_MEASURE_NOISE, pick_register_value());
        if ($urandom_range(0, 3) == 0) begin
          write_register(CFG_IDX_W'($urandom_range(4, 15)), REG_W'($urandom));
        end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_word(ANGLE_SPAN), pick_word(RATE_SPAN));
      end
      wait_for_results();
    end

    if (board.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/kab_pkg.sv
design/kab_mul.sv
design/kab_div.sv
design/kalman_angle_bias_filter.sv
tb/kalman_angle_bias_filter_tb.sv
